@@ sv/aesp_pkg.sv @@
// ----------------------------------------------------------------------------
// aesp_pkg: shared types and constants of the escape sequence parser
// Byte codes, event kinds and the command/status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package aesp_pkg;

  // Byte codes the parser reacts to
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_LBR   = 8'h5B;  // '['
  localparam logic [7:0] BYTE_M     = 8'h4D;  // 'M'
  localparam logic [7:0] BYTE_QMARK = 8'h3F;  // '?'
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] BYTE_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] BYTE_NINE  = 8'h39;  // '9'

  // Result field widths
  localparam int unsigned IdxW = 4;
  localparam int unsigned ValW = 16;

  // Event kinds on the result channel
  typedef enum logic [1:0] {
    EV_CHAR = 2'd0,
    EV_RI   = 2'd1,
    EV_CMD  = 2'd2
  } ev_kind_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic     out_load;    // load the output register
    ev_kind_e out_kind;    // kind of the item being loaded
    logic     clr_params;  // opening a control sequence: clear all slots
    logic     inc_count;   // advance to the next parameter slot
    logic     accum;       // fold a decimal digit into the current slot
    logic     emit_init;   // latch final byte, restart emit index
    logic     emit_step;   // emit one parameter, move emit index on
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic byte_esc;
    logic byte_lbr;
    logic byte_m;
    logic byte_qmark;
    logic byte_semi;
    logic byte_digit;
    logic count_full;  // current slot is the last one
    logic emit_last;   // emit index points at the last slot in use
    logic out_free;    // output register can take an item this cycle
  } stat_t;

endpackage

@@ sv/aesp_ctrl.sv @@
// ----------------------------------------------------------------------------
// aesp_ctrl: parser controller
// Tracks the escape state, owns the input handshake and sequences the
// emission of stored parameters after a final byte.
// ----------------------------------------------------------------------------
module aesp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aesp_pkg::stat_t stat_i,
  output aesp_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_NORMAL,
    ST_ESC,
    ST_OPEN,
    ST_PARAMS,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  // Input taken in any parsing state while the output register has room
  assign in_ready_o = (state_q != ST_EMIT) && stat_i.out_free;
  assign acc        = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_kind = aesp_pkg::EV_CHAR;
    case (state_q)
      ST_NORMAL: begin
        if (acc) begin
          if (stat_i.byte_esc) begin
            state_d = ST_ESC;
          end else begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = aesp_pkg::EV_CHAR;
          end
        end
      end
      ST_ESC: begin
        if (acc) begin
          state_d = ST_NORMAL;
          if (stat_i.byte_lbr) begin
            state_d = ST_OPEN;
          end else if (stat_i.byte_m) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = aesp_pkg::EV_RI;
          end
        end
      end
      ST_OPEN, ST_PARAMS: begin
        if (acc) begin
          state_d          = ST_PARAMS;
          cmd_o.clr_params = (state_q == ST_OPEN);
          if ((state_q == ST_OPEN) && stat_i.byte_qmark) begin
            // leading '?' is skipped
          end else if (stat_i.byte_semi &&
                       ((state_q == ST_OPEN) || !stat_i.count_full)) begin
            // slot zero is not the last one right after '[' when MAX_PARAMS > 1
            cmd_o.inc_count = 1'b1;
          end else if (stat_i.byte_digit) begin
            cmd_o.accum = 1'b1;
          end else begin
            cmd_o.emit_init = 1'b1;
            state_d         = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_kind  = aesp_pkg::EV_CMD;
          cmd_o.emit_step = 1'b1;
          if (stat_i.emit_last) begin
            state_d = ST_NORMAL;
          end
        end
      end
      default: begin
        state_d = ST_NORMAL;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_NORMAL;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/aesp_dp.sv @@
// ----------------------------------------------------------------------------
// aesp_dp: parser datapath
// Parameter slots with valid bits, slot counter, decimal accumulator with
// saturation, emit counter and the output register.
// ----------------------------------------------------------------------------
module aesp_dp #(
  parameter int unsigned MAX_PARAMS  = 16,
  parameter int unsigned PARAM_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      byte_in_i,
  input  aesp_pkg::cmd_t  cmd_i,
  output aesp_pkg::stat_t stat_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      event_kind_o,
  output logic [7:0]      code_o,
  output logic [aesp_pkg::IdxW-1:0] param_index_o,
  output logic [aesp_pkg::ValW-1:0] param_value_o,
  output logic            last_o
);

  localparam int unsigned CntW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned AccW = PARAM_WIDTH + 4;
  localparam logic [CntW-1:0] LastSlot = CntW'(MAX_PARAMS - 1);
  localparam logic [AccW-1:0] ParamMax = {4'b0, {PARAM_WIDTH{1'b1}}};

  logic [PARAM_WIDTH-1:0] store_q [MAX_PARAMS];
  logic [MAX_PARAMS-1:0]  vld_q, vld_d;
  logic [CntW-1:0]        count_q, count_d, base_idx;
  logic [CntW-1:0]        emit_idx_q, rd_addr;
  logic [7:0]             final_q;
  logic [PARAM_WIDTH-1:0] rd_val, cur_val, new_val;
  logic [AccW-1:0]        mul10;
  logic [3:0]             digit;

  // Output register
  logic                       out_valid_q;
  aesp_pkg::ev_kind_e         kind_q;
  logic [7:0]                 code_q;
  logic [aesp_pkg::IdxW-1:0]  idx_q;
  logic [aesp_pkg::ValW-1:0]  val_q;
  logic                       last_q;

  // Byte classification
  always_comb begin
    stat_o            = '0;
    stat_o.byte_esc   = (byte_in_i == aesp_pkg::BYTE_ESC);
    stat_o.byte_lbr   = (byte_in_i == aesp_pkg::BYTE_LBR);
    stat_o.byte_m     = (byte_in_i == aesp_pkg::BYTE_M);
    stat_o.byte_qmark = (byte_in_i == aesp_pkg::BYTE_QMARK);
    stat_o.byte_semi  = (byte_in_i == aesp_pkg::BYTE_SEMI);
    stat_o.byte_digit = (byte_in_i >= aesp_pkg::BYTE_ZERO) &&
                        (byte_in_i <= aesp_pkg::BYTE_NINE);
    stat_o.count_full = (count_q == LastSlot);
    stat_o.emit_last  = (emit_idx_q == count_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Slot read: emit index while emitting, else the current slot
  assign rd_addr  = cmd_i.emit_step ? emit_idx_q : count_q;
  assign rd_val   = vld_q[rd_addr] ? store_q[rd_addr] : '0;
  // A slot being cleared this cycle reads as zero
  assign cur_val  = cmd_i.clr_params ? '0 : rd_val;
  assign base_idx = cmd_i.clr_params ? '0 : count_q;

  // value * 10 + digit, saturating
  assign digit   = byte_in_i[3:0];
  assign mul10   = {1'b0, cur_val, 3'b000} + {3'b000, cur_val, 1'b0} +
                   {{(AccW-4){1'b0}}, digit};
  assign new_val = (mul10 > ParamMax) ? {PARAM_WIDTH{1'b1}} : mul10[PARAM_WIDTH-1:0];

  // Slot counter and valid bits
  always_comb begin
    count_d = count_q;
    vld_d   = vld_q;
    if (cmd_i.clr_params) begin
      count_d = '0;
      vld_d   = '0;
    end
    if (cmd_i.inc_count) begin
      count_d = base_idx + 1'b1;
    end
    if (cmd_i.accum) begin
      vld_d[base_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      vld_q      <= '0;
      emit_idx_q <= '0;
    end else begin
      count_q <= count_d;
      vld_q   <= vld_d;
      if (cmd_i.emit_init) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_step) begin
        emit_idx_q <= emit_idx_q + 1'b1;
      end
    end
  end

  // Slot store and final byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      store_q[base_idx] <= new_val;
    end
    if (cmd_i.emit_init) begin
      final_q <= byte_in_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q <= cmd_i.out_kind;
      if (cmd_i.out_kind == aesp_pkg::EV_CMD) begin
        code_q <= final_q;
        idx_q  <= aesp_pkg::IdxW'(emit_idx_q);
        val_q  <= aesp_pkg::ValW'(rd_val);
        last_q <= stat_o.emit_last;
      end else begin
        code_q <= byte_in_i;
        idx_q  <= '0;
        val_q  <= '0;
        last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign code_o        = code_q;
  assign param_index_o = idx_q;
  assign param_value_o = val_q;
  assign last_o        = last_q;

endmodule

@@ sv/ansi_escape_sequence_parser_core.sv @@
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser_core: terminal escape sequence parser
// Classifies a console byte stream into characters, reverse index and
// control sequence commands with their decimal parameters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, byte_in_i) takes one console byte
//   per item. Output channel (out_valid_o/out_ready_i) delivers result items:
//   event_kind_o, code_o, param_index_o, param_value_o, last_o.
//   A plain character or ESC M appears on the output in the cycle after it is
//   taken. A final byte makes count+1 command items, one per cycle from the
//   output register while the receiver is ready, each read from the parameter
//   slot registers; the input is held off until the last of them is loaded.
//   Bytes are taken one per cycle while the output register has room.
//   Reset puts the parser in the normal state with all slots clear.
//   While the receiver stalls the output register holds its item and the
//   input stays not ready.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_parser_core #(
  parameter int unsigned MAX_PARAMS  = 16,
  parameter int unsigned PARAM_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  code_o,
  output logic [3:0]  param_index_o,
  output logic [15:0] param_value_o,
  output logic        last_o
);

  aesp_pkg::cmd_t  cmd;
  aesp_pkg::stat_t stat;

  aesp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  aesp_dp #(
    .MAX_PARAMS  (MAX_PARAMS),
    .PARAM_WIDTH (PARAM_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_in_i     (byte_in_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .code_o        (code_o),
    .param_index_o (param_index_o),
    .param_value_o (param_value_o),
    .last_o        (last_o)
  );

  // An item is only taken when the output register has room
  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !(out_valid_o && !out_ready_i))
    else $error("input taken while output register is blocked");

  // Character and reverse index events are single items
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o != aesp_pkg::EV_CMD)) |-> last_o)
    else $error("non-command event without last");

  // No byte is taken in the middle of a command burst
  a_burst_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o == aesp_pkg::EV_CMD) && !last_o) |-> !in_ready_o)
    else $error("input ready during a command burst");

endmodule
